@@ hw/rtl/imh_pkg.sv @@
// Package: shared types and constants of the indexed min-heap.
package imh_pkg;
	localparam int SLOTS = 256;
	localparam int HANDLES = 256;
	localparam int PW = $clog2(SLOTS);
	localparam int HW = $clog2(HANDLES);
	localparam int CW = 32;
	localparam logic [PW-1:0] CAPACITY = PW'(SLOTS - 1);

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_APPEND = 3'd1,
		OP_BUILD = 3'd2,
		OP_DECREASE = 3'd3,
		OP_EXTRACT = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_EMPTY = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] item_handle;
		logic [31:0] item_cost;
	} req_t;

	typedef struct packed {
		logic [7:0] out_handle;
		logic [31:0] out_cost;
		logic [1:0] status;
		logic [7:0] entry_count;
	} rsp_t;
endpackage

@@ hw/rtl/imh_stream_if.sv @@
// Interface: valid/ready stream channel carrying one payload beat.
interface imh_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/indexed_min_heap.sv @@
// Top level: indexed binary min-heap with ordered insert, append, build, decrease-key and extract.
// Append places the entry without moving it; insert and decrease sift it up; extract moves
// the last slot to the root and sifts it down unless that empties the heap; build sifts down
// every internal slot. Requests are taken one at a time, each once the last result is
// registered. Reset clears the position table before the first request is taken.
module indexed_min_heap (
	input logic clk,
	input logic arst_n,
	imh_stream_if.sink in_ch,
	imh_stream_if.source out_ch
);
	localparam int PW = imh_pkg::PW;
	localparam int HW = imh_pkg::HW;

	// Memories: heap slots and position table. Read data is registered, so an
	// address set in one state delivers its data in the next state.
	logic [31:0] cost_mem [imh_pkg::SLOTS];
	logic [7:0] hnd_mem [imh_pkg::SLOTS];
	logic [PW-1:0] pos_mem [imh_pkg::HANDLES];

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_LOOKUP, S_LOOKW, S_DISPATCH,
		S_UP_RD, S_UP_CMP,
		S_DN_RDL, S_DN_RDR, S_DN_CMPR,
		S_EX_RD, S_EX_RDL, S_EX_TAKE,
		S_BLD_NEXT, S_BLD_RD,
		S_PLACE, S_RESP
	} state_t;

	state_t state_q;
	imh_pkg::req_t req_q;
	logic [PW-1:0] fill_q;
	logic [PW-1:0] n_q;
	logic [PW-1:0] idx_q;
	logic [HW-1:0] clr_q;
	logic [PW-1:0] pos_q, best_q;
	logic [31:0] cost_q, bcost_q;
	logic [7:0] hnd_q, bhnd_q;
	logic [31:0] rc_q;
	logic [7:0] rh_q;
	imh_pkg::status_t status_q;
	logic bld_q; // the sift-down belongs to a build pass
	logic out_valid_q;
	imh_pkg::rsp_t out_q;

	// Memory ports.
	logic [PW-1:0] rd_addr;
	logic [31:0] rd_cost;
	logic [7:0] rd_hnd;
	logic [PW-1:0] rd_pos;
	logic [HW-1:0] prd_addr;
	logic wr_en;
	logic [PW-1:0] wr_addr;
	logic [31:0] wr_cost;
	logic [7:0] wr_hnd;
	logic pw_en;
	logic [HW-1:0] pw_addr;
	logic [PW-1:0] pw_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cost_mem[wr_addr] <= wr_cost;
			hnd_mem[wr_addr] <= wr_hnd;
		end
		if (pw_en)
			pos_mem[pw_addr] <= pw_data;
		rd_cost <= cost_mem[rd_addr];
		rd_hnd <= hnd_mem[rd_addr];
		rd_pos <= pos_mem[prd_addr];
	end

	// Child indexes carry one extra bit so that they can be compared with the
	// entry count without wrapping.
	logic [PW:0] lft, rgt;
	assign lft = {pos_q, 1'b0};
	assign rgt = {pos_q, 1'b1};

	// A handle is present when its position points inside the filled part.
	logic present;
	assign present = rd_pos != '0 && rd_pos <= fill_q;

	// The single compare unit is shared by every state that orders two costs.
	logic [31:0] cmp_cand, cmp_best;
	logic cmp_en;
	logic take;

	always_comb begin
		cmp_cand = cost_q;
		cmp_best = rd_cost;
		cmp_en = 1'b1;
		case (state_q)
			S_DISPATCH: cmp_cand = req_q.item_cost;
			S_DN_RDR: begin
				cmp_cand = rd_cost;
				cmp_best = cost_q;
			end
			S_DN_CMPR: begin
				cmp_cand = rd_cost;
				cmp_best = bcost_q;
				cmp_en = rgt <= {1'b0, n_q};
			end
			default: ;
		endcase
	end

	imh_cmp u_cmp (
		.best_cost(cmp_best),
		.cand_cost(cmp_cand),
		.cand_valid(cmp_en),
		.take(take)
	);

	// Sift-down choice after the right child has been compared.
	logic [PW-1:0] dn_pick;
	logic [31:0] dn_pick_cost;
	logic [7:0] dn_pick_hnd;
	assign dn_pick = take ? rgt[PW-1:0] : best_q;
	assign dn_pick_cost = take ? rd_cost : bcost_q;
	assign dn_pick_hnd = take ? rd_hnd : bhnd_q;

	// Combinational memory control derived from the state.
	always_comb begin
		rd_addr = pos_q;
		prd_addr = req_q.item_handle[HW-1:0];
		wr_en = 1'b0;
		wr_addr = pos_q;
		wr_cost = cost_q;
		wr_hnd = hnd_q;
		pw_en = 1'b0;
		pw_addr = hnd_q[HW-1:0];
		pw_data = pos_q;
		case (state_q)
			S_CLEAR: begin
				pw_en = 1'b1;
				pw_addr = clr_q;
				pw_data = '0;
			end
			S_LOOKW: rd_addr = rd_pos;
			S_UP_RD: rd_addr = pos_q >> 1;
			S_UP_CMP: if (take) begin
				// The parent is greater, so it moves down into this slot.
				wr_en = 1'b1;
				wr_cost = rd_cost;
				wr_hnd = rd_hnd;
				pw_en = 1'b1;
				pw_addr = rd_hnd[HW-1:0];
			end
			S_DN_RDL: rd_addr = lft[PW-1:0];
			S_DN_RDR: rd_addr = rgt[PW-1:0];
			S_DN_CMPR: if (dn_pick != pos_q) begin
				// The smaller child moves up into this slot.
				wr_en = 1'b1;
				wr_cost = dn_pick_cost;
				wr_hnd = dn_pick_hnd;
				pw_en = 1'b1;
				pw_addr = dn_pick_hnd[HW-1:0];
			end
			S_EX_RD: rd_addr = PW'(1);
			S_EX_RDL: rd_addr = fill_q;
			S_EX_TAKE: begin
				// The removed handle becomes absent.
				pw_en = 1'b1;
				pw_addr = rh_q[HW-1:0];
				pw_data = '0;
			end
			S_BLD_NEXT: rd_addr = idx_q;
			S_PLACE: begin
				wr_en = 1'b1;
				pw_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RESP && (!out_valid_q || out_ch.ready))
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == HW'(imh_pkg::HANDLES - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: if (in_ch.valid) begin
					req_q <= in_ch.data;
					state_q <= S_LOOKUP;
					rc_q <= '0;
					rh_q <= '0;
					status_q <= imh_pkg::ST_DONE;
					bld_q <= 1'b0;
				end
				// The position read is in flight, then the slot it names.
				S_LOOKUP: state_q <= S_LOOKW;
				S_LOOKW: state_q <= S_DISPATCH;
				S_DISPATCH: begin
					hnd_q <= req_q.item_handle;
					cost_q <= req_q.item_cost;
					case (req_q.operation)
						imh_pkg::OP_INSERT, imh_pkg::OP_DECREASE: begin
							if (present) begin
								// A present handle only moves when its cost drops.
								if (take) begin
									pos_q <= rd_pos;
									state_q <= S_UP_RD;
								end else begin
									status_q <= imh_pkg::ST_IGNORED;
									state_q <= S_RESP;
								end
							end else if (req_q.operation == imh_pkg::OP_DECREASE) begin
								status_q <= imh_pkg::ST_IGNORED;
								state_q <= S_RESP;
							end else if (fill_q >= imh_pkg::CAPACITY) begin
								status_q <= imh_pkg::ST_FULL;
								state_q <= S_RESP;
							end else begin
								fill_q <= fill_q + 1'b1;
								pos_q <= fill_q + 1'b1;
								state_q <= S_UP_RD;
							end
						end
						imh_pkg::OP_APPEND: begin
							// A present handle keeps its slot and gets the new cost.
							if (present) begin
								pos_q <= rd_pos;
								state_q <= S_PLACE;
							end else if (fill_q >= imh_pkg::CAPACITY) begin
								status_q <= imh_pkg::ST_FULL;
								state_q <= S_RESP;
							end else begin
								fill_q <= fill_q + 1'b1;
								pos_q <= fill_q + 1'b1;
								state_q <= S_PLACE;
							end
						end
						imh_pkg::OP_BUILD: begin
							n_q <= fill_q;
							idx_q <= fill_q >> 1;
							bld_q <= 1'b1;
							state_q <= S_BLD_NEXT;
						end
						imh_pkg::OP_EXTRACT: begin
							if (fill_q == '0) begin
								status_q <= imh_pkg::ST_EMPTY;
								state_q <= S_RESP;
							end else
								state_q <= S_EX_RD;
						end
						default: state_q <= S_RESP;
					endcase
				end
				// Sift-up: one parent read and one compare per level.
				S_UP_RD: begin
					if (pos_q > PW'(1))
						state_q <= S_UP_CMP;
					else
						state_q <= S_PLACE;
				end
				S_UP_CMP: begin
					if (take) begin
						pos_q <= pos_q >> 1;
						state_q <= S_UP_RD;
					end else
						state_q <= S_PLACE;
				end
				// Extract: read the root, then the last slot, then sift down unless the heap is now empty.
				S_EX_RD: state_q <= S_EX_RDL;
				S_EX_RDL: begin
					rc_q <= rd_cost;
					rh_q <= rd_hnd;
					state_q <= S_EX_TAKE;
				end
				S_EX_TAKE: begin
					cost_q <= rd_cost;
					hnd_q <= rd_hnd;
					fill_q <= fill_q - 1'b1;
					n_q <= fill_q - 1'b1;
					pos_q <= PW'(1);
					if (fill_q == PW'(1))
						state_q <= S_RESP;
					else
						state_q <= S_DN_RDL;
				end
				// Sift-down: read left, read right, compare each in the shared unit.
				S_DN_RDL: begin
					if (lft > {1'b0, n_q})
						state_q <= S_PLACE;
					else
						state_q <= S_DN_RDR;
				end
				S_DN_RDR: begin
					// Left child data is here; ties keep the entry in place.
					if (take) begin
						best_q <= lft[PW-1:0];
						bcost_q <= rd_cost;
						bhnd_q <= rd_hnd;
					end else begin
						best_q <= pos_q;
						bcost_q <= cost_q;
						bhnd_q <= hnd_q;
					end
					state_q <= S_DN_CMPR;
				end
				S_DN_CMPR: begin
					if (dn_pick == pos_q)
						state_q <= S_PLACE;
					else begin
						pos_q <= dn_pick;
						state_q <= S_DN_RDL;
					end
				end
				// Build: sift down every internal slot, from the last one to the root.
				S_BLD_NEXT: begin
					if (idx_q == '0)
						state_q <= S_RESP;
					else begin
						pos_q <= idx_q;
						state_q <= S_BLD_RD;
					end
				end
				S_BLD_RD: begin
					cost_q <= rd_cost;
					hnd_q <= rd_hnd;
					state_q <= S_DN_RDL;
				end
				S_PLACE: begin
					if (bld_q) begin
						idx_q <= idx_q - 1'b1;
						state_q <= S_BLD_NEXT;
					end else
						state_q <= S_RESP;
				end
				S_RESP: if (!out_valid_q || out_ch.ready) begin
					out_q.out_handle <= rh_q;
					out_q.out_cost <= rc_q;
					out_q.status <= status_q;
					out_q.entry_count <= 8'(fill_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready = state_q == S_IDLE;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;
endmodule

@@ hw/rtl/imh_cmp.sv @@
// Shared compare unit: picks the smaller of a candidate against a running best.
module imh_cmp (
	input logic [31:0] best_cost,
	input logic [31:0] cand_cost,
	input logic cand_valid,
	output logic take
);
	// Strictly smaller only, so ties keep the earlier choice.
	assign take = cand_valid && (cand_cost < best_cost);
endmodule
